// ----- sv/grid_align_point_clusters_core_macros.svh -----
// Assertion macros shared by the grid alignment block.
`ifndef GRID_ALIGN_POINT_CLUSTERS_CORE_MACROS_SVH
`define GRID_ALIGN_POINT_CLUSTERS_CORE_MACROS_SVH

// Checked only while out of reset.
`define GAPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, including during reset.
`define GAPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/gapc_pkg.sv -----
package gapc_pkg;

  // Defaults and fixed widths.
  localparam int MaxPointsDef = 64;
  localparam int CoordBitsDef = 12;
  localparam int TolW         = 12;
  localparam int RadW         = 16;
  localparam logic [TolW-1:0] TolReset = 12'd20;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R_LDP,
    ST_R_CAP,
    ST_R_SCAN,
    ST_R_WR,
    ST_G_LO,
    ST_G_LP,
    ST_G_LC,
    ST_G_SCAN,
    ST_G_UPD,
    ST_D_LD,
    ST_D_INIT,
    ST_D_RUN,
    ST_S_O,
    ST_S_P,
    ST_S_G,
    ST_O_O,
    ST_O_P,
    ST_O_E
  } gapc_state_e;

endpackage

// ----- sv/grid_align_point_clusters_core.sv -----
// Channel   | Ports                                         | Timing
// ----------+-----------------------------------------------+--------------------------
// input     | start_i, busy_o, in_x/y/radius/last_i          | taken when start_i & !busy_o
// result    | out_strobe_o, out_x/y/radius/last_o            | one word per strobe
// config    | cfg_we_i, cfg_wdata_i                          | written when cfg_we_i
//
// A point word is stored when taken, up to MaxPoints words; busy_o stays low
// until the last word. After it come ranking, then per pass grouping and, per
// group, a divide and a scatter; then the result words. One serial divider
// computes the group means. Reset is asynchronous, active low, clears the point
// count and radius and sets the tolerance to its default; results cannot stall.
module grid_align_point_clusters_core #(
  parameter int MaxPoints = gapc_pkg::MaxPointsDef,
  parameter int CoordBits = gapc_pkg::CoordBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gapc_pkg::TolW-1:0] cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [CoordBits-1:0]      in_x_i,
  input  logic [CoordBits-1:0]      in_y_i,
  input  logic [gapc_pkg::RadW-1:0] in_radius_i,
  input  logic                      in_last_i,
  output logic                      out_strobe_o,
  output logic [CoordBits-1:0]      out_x_o,
  output logic [CoordBits-1:0]      out_y_o,
  output logic [gapc_pkg::RadW-1:0] out_radius_o,
  output logic                      out_last_o
);

`include "grid_align_point_clusters_core_macros.svh"

  localparam int IW  = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CW  = CoordBits;
  localparam int SW  = CW + IW;
  localparam int NB  = SW + 1;
  localparam int DW  = IW + 2;
  localparam int RW  = IW + 3;
  localparam int GMW = CW + SW + IW + 1;
  localparam int MW  = (CW > gapc_pkg::TolW) ? CW : gapc_pkg::TolW;
  localparam int SCW = $clog2(NB);
  localparam int PD  = 2 ** IW;

  // Memories: coordinates, point orders (two buffers), group per point, group table.
  logic [CW-1:0]  x_mem   [PD];
  logic [CW-1:0]  y_mem   [PD];
  logic [IW-1:0]  ord_mem [2*PD];
  logic [IW-1:0]  grp_mem [PD];
  logic [GMW-1:0] gm_mem  [PD];

  gapc_pkg::gapc_state_e state_q, state_d;

  logic [IW:0]   cnt_q, cnt_d, ng_q, ng_d;
  logic [gapc_pkg::RadW-1:0] rad_q, rad_d;
  logic [gapc_pkg::TolW-1:0] tol_q;
  logic [IW-1:0] p_q, p_d, j_q, j_d, i_q, i_d, g_q, g_d, rank_q, rank_d, k_q, k_d;
  logic [IW-1:0] nm1_q, nm1_d;
  logic [CW-1:0] xp_q, xp_d, c_q, c_d, quo_q, quo_d;
  logic          axis_q, axis_d, join_q, join_d;
  logic [SW-1:0] gsum_q, gsum_d;
  logic [IW:0]   gcnt_q, gcnt_d;
  logic [NB-1:0] num_q, num_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [SCW-1:0] dstep_q, dstep_d;

  // Memory ports.
  logic [IW-1:0]  c_ra, c_wa, grp_ra, grp_wa, gm_ra, gm_wa;
  logic [IW:0]    ord_ra, ord_wa;
  logic           x_we, y_we, ord_we, grp_we, gm_we;
  logic [CW-1:0]  x_wd, y_wd;
  logic [IW-1:0]  ord_wd, grp_wd;
  logic [GMW-1:0] gm_wd;
  logic [CW-1:0]  x_rd_q, y_rd_q;
  logic [IW-1:0]  ord_rd_q, grp_rd_q;
  logic [GMW-1:0] gm_rd_q;

  // Shared arithmetic.
  logic [CW-1:0] crd, gm_new, diff;
  logic [SW-1:0] gm_sum;
  logic [IW:0]   gm_cnt;
  logic          near, less, accept, qbit;
  logic [RW-1:0] trial;
  logic [IW-1:0] gidx;

  assign accept = start_i && (state_q == gapc_pkg::ST_IDLE);
  assign crd    = axis_q ? y_rd_q : x_rd_q;
  assign gm_new = gm_rd_q[GMW-1 -: CW];
  assign gm_sum = gm_rd_q[IW+SW -: SW];
  assign gm_cnt = gm_rd_q[IW:0];
  assign diff   = (c_q > gm_new) ? (c_q - gm_new) : (gm_new - c_q);
  assign near   = MW'(diff) <= MW'(tol_q);
  assign less   = (x_rd_q < xp_q) || ((x_rd_q == xp_q) && (j_q < p_q));
  assign trial  = {rem_q[RW-2:0], num_q[NB-1]};
  assign qbit   = trial >= RW'(den_q);
  assign gidx   = join_q ? g_q : ng_q[IW-1:0];

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[c_wa] <= x_wd;
    if (y_we) y_mem[c_wa] <= y_wd;
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (grp_we) grp_mem[grp_wa] <= grp_wd;
    if (gm_we) gm_mem[gm_wa] <= gm_wd;
    x_rd_q   <= x_mem[c_ra];
    y_rd_q   <= y_mem[c_ra];
    ord_rd_q <= ord_mem[ord_ra];
    grp_rd_q <= grp_mem[grp_ra];
    gm_rd_q  <= gm_mem[gm_ra];
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gapc_pkg::ST_IDLE;
      cnt_q   <= '0;
      rad_q   <= '0;
      tol_q   <= gapc_pkg::TolReset;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rad_q   <= rad_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    ng_q <= ng_d;   p_q <= p_d;     j_q <= j_d;       i_q <= i_d;
    g_q <= g_d;     rank_q <= rank_d; k_q <= k_d;     nm1_q <= nm1_d;
    xp_q <= xp_d;   c_q <= c_d;     quo_q <= quo_d;   axis_q <= axis_d;
    join_q <= join_d; gsum_q <= gsum_d; gcnt_q <= gcnt_d;
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;   dstep_q <= dstep_d;
  end

  // Sequencer: load, rank sort, two grouping passes, output.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;   rad_d = rad_q;   ng_d = ng_q;   p_d = p_q;   j_d = j_q;
    i_d = i_q;       g_d = g_q;       rank_d = rank_q; k_d = k_q; nm1_d = nm1_q;
    xp_d = xp_q;     c_d = c_q;       quo_d = quo_q; axis_d = axis_q;
    join_d = join_q; gsum_d = gsum_q; gcnt_d = gcnt_q;
    num_d = num_q;   rem_d = rem_q;   den_d = den_q; dstep_d = dstep_q;
    c_ra = '0;   c_wa = '0;   ord_ra = '0; ord_wa = '0;
    grp_ra = '0; grp_wa = '0; gm_ra = '0;  gm_wa = '0;
    x_we = 1'b0; y_we = 1'b0; ord_we = 1'b0; grp_we = 1'b0; gm_we = 1'b0;
    x_wd = in_x_i; y_wd = in_y_i; ord_wd = p_q; grp_wd = gidx; gm_wd = '0;
    out_strobe_o = 1'b0;
    out_last_o   = 1'b0;

    unique case (state_q)
      gapc_pkg::ST_IDLE: begin
        if (accept) begin
          c_wa = cnt_q[IW-1:0];
          if (cnt_q < (IW+1)'(MaxPoints)) begin
            x_we  = 1'b1;
            y_we  = 1'b1;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) rad_d = in_radius_i;
          end
          if (in_last_i) begin
            nm1_d   = IW'(cnt_d - 1'b1);
            p_d     = '0;
            state_d = gapc_pkg::ST_R_LDP;
          end
        end
      end

      // Rank of each point: count points ahead of it in stable x order.
      gapc_pkg::ST_R_LDP: begin
        c_ra    = p_q;
        state_d = gapc_pkg::ST_R_CAP;
      end
      gapc_pkg::ST_R_CAP: begin
        xp_d    = x_rd_q;
        c_ra    = '0;
        j_d     = '0;
        rank_d  = '0;
        state_d = gapc_pkg::ST_R_SCAN;
      end
      gapc_pkg::ST_R_SCAN: begin
        c_ra   = j_q + 1'b1;
        rank_d = rank_q + IW'(less);
        if (j_q == nm1_q) begin
          state_d = gapc_pkg::ST_R_WR;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      gapc_pkg::ST_R_WR: begin
        ord_we = 1'b1;
        ord_wa = {1'b0, rank_q};
        if (p_q == nm1_q) begin
          axis_d  = 1'b0;
          i_d     = '0;
          ng_d    = '0;
          k_d     = '0;
          state_d = gapc_pkg::ST_G_LO;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = gapc_pkg::ST_R_LDP;
        end
      end

      // Group assignment: find the first group whose newest member is near.
      gapc_pkg::ST_G_LO: begin
        ord_ra  = {axis_q, i_q};
        state_d = gapc_pkg::ST_G_LP;
      end
      gapc_pkg::ST_G_LP: begin
        p_d     = ord_rd_q;
        c_ra    = ord_rd_q;
        state_d = gapc_pkg::ST_G_LC;
      end
      gapc_pkg::ST_G_LC: begin
        c_d     = crd;
        gm_ra   = '0;
        g_d     = '0;
        join_d  = 1'b0;
        state_d = (ng_q == '0) ? gapc_pkg::ST_G_UPD : gapc_pkg::ST_G_SCAN;
      end
      gapc_pkg::ST_G_SCAN: begin
        gm_ra = g_q + 1'b1;
        if (near) begin
          join_d  = 1'b1;
          gsum_d  = gm_sum;
          gcnt_d  = gm_cnt;
          state_d = gapc_pkg::ST_G_UPD;
        end else if ((IW+1)'(g_q) + 1'b1 == ng_q) begin
          state_d = gapc_pkg::ST_G_UPD;
        end else begin
          g_d = g_q + 1'b1;
        end
      end
      gapc_pkg::ST_G_UPD: begin
        gm_we  = 1'b1;
        gm_wa  = gidx;
        gm_wd  = join_q ? {c_q, gsum_q + SW'(c_q), gcnt_q + 1'b1}
                        : {c_q, SW'(c_q), (IW+1)'(1)};
        grp_we = 1'b1;
        grp_wa = p_q;
        if (!join_q) ng_d = ng_q + 1'b1;
        if (i_q == nm1_q) begin
          g_d     = '0;
          state_d = gapc_pkg::ST_D_LD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = gapc_pkg::ST_G_LO;
        end
      end

      // Group mean, rounded half up, by a serial restoring divider.
      gapc_pkg::ST_D_LD: begin
        gm_ra   = g_q;
        state_d = gapc_pkg::ST_D_INIT;
      end
      gapc_pkg::ST_D_INIT: begin
        num_d   = {gm_sum, 1'b0} + NB'(gm_cnt);
        den_d   = {gm_cnt, 1'b0};
        rem_d   = '0;
        dstep_d = '0;
        state_d = gapc_pkg::ST_D_RUN;
      end
      gapc_pkg::ST_D_RUN: begin
        rem_d   = qbit ? (trial - RW'(den_q)) : trial;
        num_d   = {num_q[NB-2:0], 1'b0};
        quo_d   = {quo_q[CW-2:0], qbit};
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == SCW'(NB - 1)) begin
          i_d     = '0;
          state_d = gapc_pkg::ST_S_O;
        end
      end

      // Scatter the mean to the group's members and list them in order.
      gapc_pkg::ST_S_O: begin
        ord_ra  = {axis_q, i_q};
        state_d = gapc_pkg::ST_S_P;
      end
      gapc_pkg::ST_S_P: begin
        p_d     = ord_rd_q;
        grp_ra  = ord_rd_q;
        state_d = gapc_pkg::ST_S_G;
      end
      gapc_pkg::ST_S_G: begin
        c_wa = p_q;
        x_wd = quo_q;
        y_wd = quo_q;
        ord_wa = {~axis_q, k_q};
        if (grp_rd_q == g_q) begin
          x_we   = !axis_q;
          y_we   = axis_q;
          ord_we = 1'b1;
          k_d    = k_q + 1'b1;
        end
        if (i_q != nm1_q) begin
          i_d     = i_q + 1'b1;
          state_d = gapc_pkg::ST_S_O;
        end else if ((IW+1)'(g_q) + 1'b1 != ng_q) begin
          g_d     = g_q + 1'b1;
          state_d = gapc_pkg::ST_D_LD;
        end else if (!axis_q) begin
          axis_d  = 1'b1;
          i_d     = '0;
          ng_d    = '0;
          k_d     = '0;
          state_d = gapc_pkg::ST_G_LO;
        end else begin
          i_d     = '0;
          state_d = gapc_pkg::ST_O_O;
        end
      end

      // Result words, row group by row group.
      gapc_pkg::ST_O_O: begin
        ord_ra  = {1'b0, i_q};
        state_d = gapc_pkg::ST_O_P;
      end
      gapc_pkg::ST_O_P: begin
        c_ra    = ord_rd_q;
        state_d = gapc_pkg::ST_O_E;
      end
      gapc_pkg::ST_O_E: begin
        out_strobe_o = 1'b1;
        out_last_o   = (i_q == nm1_q);
        if (i_q == nm1_q) begin
          cnt_d   = '0;
          state_d = gapc_pkg::ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = gapc_pkg::ST_O_O;
        end
      end

      default: state_d = gapc_pkg::ST_IDLE;
    endcase
  end

  assign busy_o       = (state_q != gapc_pkg::ST_IDLE);
  assign out_x_o      = x_rd_q;
  assign out_y_o      = y_rd_q;
  assign out_radius_o = rad_q;

  // Checks.
  `GAPC_ASSERT(a_strobe_busy, out_strobe_o |-> busy_o, "result word while idle")
  `GAPC_ASSERT(a_last_busy, (start_i && !busy_o && in_last_i) |=> busy_o,
               "last word did not start processing")
  `GAPC_ASSERT(a_last_idle, (out_strobe_o && out_last_o) |=> (!busy_o && cnt_q == '0),
               "block not idle after final word")
  `GAPC_ASSERT_ALWAYS(a_rst_idle, (!rst_ni) |=> !busy_o, "busy straight after reset")

endmodule

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPts      = gapc_pkg::MaxPointsDef;
  localparam int CoordW      = gapc_pkg::CoordBitsDef;
  localparam int LimitCycles = 3000000;
  localparam int SettleWait  = 40;

  typedef struct {
    logic [CoordW-1:0]         x;
    logic [CoordW-1:0]         y;
    logic [gapc_pkg::RadW-1:0] radius;
    logic                      last;
  } circle_t;

  typedef struct {
    circle_t pt;
    bit      typed;
    circle_t want;
  } row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [gapc_pkg::TolW-1:0] cfg_wdata_i = '0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic [CoordW-1:0]         in_x_i = '0;
  logic [CoordW-1:0]         in_y_i = '0;
  logic [gapc_pkg::RadW-1:0] in_radius_i = '0;
  logic                      in_last_i = 1'b0;
  logic                      out_strobe_o;
  logic [CoordW-1:0]         out_x_o;
  logic [CoordW-1:0]         out_y_o;
  logic [gapc_pkg::RadW-1:0] out_radius_o;
  logic                      out_last_o;

  // Typed expectation travelling alongside the word on the input ports.
  logic              typed_hold = 1'b0;
  circle_t           typed_word;

  grid_align_point_clusters_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_radius_i (in_radius_i),
    .in_last_i   (in_last_i),
    .out_strobe_o(out_strobe_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_radius_o(out_radius_o),
    .out_last_o  (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block's state.
  logic [gapc_pkg::TolW-1:0] tol_shadow = gapc_pkg::TolReset;
  logic [CoordW-1:0]         xs_shadow [MaxPts];
  logic [CoordW-1:0]         ys_shadow [MaxPts];
  int                        pts_loaded = 0;
  logic [gapc_pkg::RadW-1:0] set_radius = '0;
  circle_t                   aligned_q [$];
  int                        mismatches = 0;
  int                        cycles = 0;

  // Appends one expected word at the tail of the queue.
  function automatic void queue_word(input circle_t w);
    aligned_q = {aligned_q, w};
  endfunction

  // Groups one axis along the given order; members take the rounded group mean
  // and the points are listed group by group.
  function automatic void group_axis(input logic [CoordW-1:0] cin [MaxPts],
                                     input int ord [MaxPts], input int n,
                                     input logic [gapc_pkg::TolW-1:0] tol,
                                     output logic [CoordW-1:0] cout [MaxPts],
                                     output int ord_out [MaxPts]);
    int newest [MaxPts];
    int sum [MaxPts];
    int cnt [MaxPts];
    int gid [MaxPts];
    int ng, g, k, c, d, m;
    ng = 0;
    k = 0;
    cout = cin;
    for (int i = 0; i < n; i++) begin
      c = cin[ord[i]];
      for (g = 0; g < ng; g++) begin
        d = c > newest[g] ? c - newest[g] : newest[g] - c;
        if (d <= tol) break;
      end
      if (g == ng) begin
        ng++;
        sum[g] = 0;
        cnt[g] = 0;
      end
      newest[g] = c;
      sum[g] += c;
      cnt[g] += 1;
      gid[ord[i]] = g;
    end
    for (g = 0; g < ng; g++) begin
      m = (2 * sum[g] + cnt[g]) / (2 * cnt[g]);
      for (int i = 0; i < n; i++) begin
        if (gid[ord[i]] == g) begin
          cout[ord[i]] = m[CoordW-1:0];
          ord_out[k] = ord[i];
          k++;
        end
      end
    end
  endfunction

  // Sorts the stored set by x, groups columns then rows, and queues the words.
  function automatic void align_set();
    int by_x [MaxPts];
    int by_col [MaxPts];
    int by_row [MaxPts];
    logic [CoordW-1:0] ax [MaxPts];
    logic [CoordW-1:0] ay [MaxPts];
    int j;
    circle_t w;
    for (int i = 0; i < pts_loaded; i++) begin
      j = i;
      while (j > 0 && xs_shadow[by_x[j-1]] > xs_shadow[i]) begin
        by_x[j] = by_x[j-1];
        j--;
      end
      by_x[j] = i;
    end
    group_axis(xs_shadow, by_x, pts_loaded, tol_shadow, ax, by_col);
    group_axis(ys_shadow, by_col, pts_loaded, tol_shadow, ay, by_row);
    for (int i = 0; i < pts_loaded; i++) begin
      w.x = ax[by_row[i]];
      w.y = ay[by_row[i]];
      w.radius = set_radius;
      w.last = (i + 1 == pts_loaded);
      queue_word(w);
    end
  endfunction

  // Accepted words, register writes and result words, all seen at the edge.
  always @(posedge clk_i) begin
    circle_t want;
    if (rst_ni && cfg_we_i) tol_shadow = cfg_wdata_i;
    if (rst_ni && start_i && !busy_o) begin
      if (pts_loaded < MaxPts) begin
        if (pts_loaded == 0) set_radius = in_radius_i;
        xs_shadow[pts_loaded] = in_x_i;
        ys_shadow[pts_loaded] = in_y_i;
        pts_loaded++;
      end
      if (in_last_i) begin
        if (typed_hold) queue_word(typed_word);
        else align_set();
        pts_loaded = 0;
      end
    end
    if (rst_ni && out_strobe_o) begin
      if (aligned_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: x=%0d y=%0d r=%h last=%b",
                   out_x_o, out_y_o, out_radius_o, out_last_o);
      end else begin
        want = aligned_q.pop_front();
        if (out_x_o !== want.x || out_y_o !== want.y ||
            out_radius_o !== want.radius || out_last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d r=%h last=%b, got x=%0d y=%0d r=%h last=%b",
                     want.x, want.y, want.radius, want.last,
                     out_x_o, out_y_o, out_radius_o, out_last_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Presents one word, with an optional random gap first, and waits until taken.
  task automatic send_word(input circle_t c, input bit typed, input circle_t want,
                           input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    in_x_i      <= c.x;
    in_y_i      <= c.y;
    in_radius_i <= c.radius;
    in_last_i   <= c.last;
    typed_hold  <= typed;
    typed_word  <= want;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Holds the sender until every word is back and the block has settled.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (aligned_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_tol(input logic [gapc_pkg::TolW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] near(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[CoordW-1:0];
  endfunction

  // Sends one set: mostly points scattered around a few column and row
  // centres, sometimes fully random coordinates.
  task automatic send_set(input int n, input int idle_pct);
    int xb [4];
    int yb [4];
    int spread;
    bit wild;
    circle_t c;
    circle_t none;
    none = '{default: '0};
    wild = ($urandom_range(3) == 0);
    spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2 * tol_shadow + 2);
    foreach (xb[i]) begin
      xb[i] = $urandom_range(0, 4095);
      yb[i] = $urandom_range(0, 4095);
    end
    for (int i = 0; i < n; i++) begin
      if (wild) begin
        c.x = CoordW'($urandom);
        c.y = CoordW'($urandom);
      end else begin
        c.x = near(xb[$urandom_range(0, 3)], spread);
        c.y = near(yb[$urandom_range(0, 3)], spread);
      end
      c.radius = gapc_pkg::RadW'($urandom);
      c.last = (i == n - 1);
      send_word(c, 1'b0, none, idle_pct);
    end
  endtask

  row_t directed [$];

  initial begin
    logic [gapc_pkg::TolW-1:0] tols [6];
    int idle_pct, sent, n;

    // Single points at the extremes, ties, a half-up mean, chained joining
    // through the newest member, and a point that joins an earlier group.
    directed = '{
      '{'{12'd4095, 12'd4095, 16'hFFFF, 1'b1}, 1'b1, '{12'd4095, 12'd4095, 16'hFFFF, 1'b1}},
      '{'{12'd0, 12'd0, 16'h0000, 1'b1}, 1'b1, '{12'd0, 12'd0, 16'h0000, 1'b1}},
      '{'{12'd100, 12'd50, 16'h0123, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd100, 12'd70, 16'hAAAA, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd100, 12'd60, 16'h5555, 1'b1}, 1'b0, '{default: '0}},
      '{'{12'd1, 12'd1, 16'h0005, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd2, 12'd2, 16'h0007, 1'b1}, 1'b0, '{default: '0}},
      '{'{12'd0, 12'd0, 16'h8000, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd15, 12'd100, 16'h0001, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd30, 12'd200, 16'h0002, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd4095, 12'd4095, 16'h0003, 1'b1}, 1'b0, '{default: '0}},
      '{'{12'd10, 12'd10, 16'h1234, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd2000, 12'd3000, 16'h4321, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd11, 12'd2990, 16'hFFFF, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd2020, 12'd9, 16'h0000, 1'b1}, 1'b0, '{default: '0}},
      '{'{12'd2048, 12'd2048, 16'h0F0F, 1'b0}, 1'b0, '{default: '0}},
      '{'{12'd2047, 12'd2047, 16'hF0F0, 1'b1}, 1'b0, '{default: '0}}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset tolerance.
    foreach (directed[i]) send_word(directed[i].pt, directed[i].typed, directed[i].want, 0);
    drain();

    // Random phases over several tolerances; idling light, heavy, then none.
    tols = '{12'd0, 12'd4095, 12'd20, 12'd1, 12'($urandom_range(2, 300)), 12'd64};
    for (int ph = 0; ph < 6; ph++) begin
      write_tol(tols[ph]);
      idle_pct = ph < 2 ? 7 : (ph < 4 ? 77 : 0);
      sent = 0;
      if (ph == 2) begin
        // A full store, then a set that overflows it.
        send_set(MaxPts, idle_pct);
        send_set(MaxPts + 6, idle_pct);
      end
      while (sent < 25) begin
        n = $urandom_range(0, 4) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_set(n, idle_pct);
        sent += n;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/gapc_pkg.sv
sv/grid_align_point_clusters_core.sv
sim/testbench.sv
